// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;

  localparam int unsigned PRIO_W = 8;
  localparam int unsigned NAME_W = 16;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic {
    MODE_ADD  = 1'b0,
    MODE_EXEC = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_EXEC  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [PRIO_W-1:0]  req_priority;
    logic [NAME_W-1:0]  req_name;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [NAME_W-1:0]  out_name;
    logic [PRIO_W-1:0]  out_priority;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [NAME_W-1:0]  name;
  } entry_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic    ins;    // insert the broadcast entry
    logic    del;    // pop the head, everyone moves one toward the head
    entry_t  ent;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted shift chain: holds, takes the new entry, or takes
// a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_cmd_t  cmd,
  input  logic                occupied,
  input  logic                left_keep,
  input  spq_pkg::entry_t     left_ent,
  input  spq_pkg::entry_t     right_ent,
  output logic                keep,
  output spq_pkg::entry_t     ent
);

  spq_pkg::entry_t ent_next;

  // An occupied slot at or below the new priority stays where it is.
  assign keep = occupied && (ent.prio <= cmd.ent.prio);

  always_comb begin
    ent_next = ent;
    if (cmd.del) begin
      ent_next = right_ent;
    end else if (cmd.ins) begin
      priority if (keep)      ent_next = ent;
      else if (left_keep)     ent_next = cmd.ent;
      else                    ent_next = left_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

// ===== hw/rtl/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue kept as a sorted chain of cells; lowest priority
// value at the head, equal priorities in arrival order.
// ----------------------------------------------------------------------------
//   channel | signals                   | dir | content
//   --------+---------------------------+-----+-----------------------------
//   request | cmd_valid cmd_ready cmd   | in  | mode, req_priority, req_name
//   result  | rsp_valid rsp_ready rsp   | out | status, name, prio, occupancy
//
// One request per cycle while results are taken: every cell compares against
// the broadcast entry in parallel and shifts in the same cycle.
// The result appears in the registered output the cycle after acceptance.
// A stalled result holds cmd_ready low until it is taken.
// Reset (rst, synchronous) empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  spq_pkg::req_t  cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output spq_pkg::rsp_t  rsp
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                fire;
  logic                full;
  logic                empty;
  spq_pkg::cell_cmd_t  cell_cmd;
  spq_pkg::rsp_t       rsp_next;

  logic                keep  [QUEUE_DEPTH];
  spq_pkg::entry_t     ent   [QUEUE_DEPTH];

  assign cmd_ready = !rsp_valid || rsp_ready;
  assign fire      = cmd_valid && cmd_ready;
  assign full      = (count == CW'(QUEUE_DEPTH));
  assign empty     = (count == '0);

  always_comb begin
    cell_cmd.ent.prio = cmd.req_priority;
    cell_cmd.ent.name = cmd.req_name;
    cell_cmd.ins      = 1'b0;
    cell_cmd.del      = 1'b0;
    count_next        = count;
    rsp_next          = '0;
    unique case (cmd.mode)
      spq_pkg::MODE_ADD: begin
        if (full) begin
          rsp_next.status = spq_pkg::ST_FULL;
        end else begin
          cell_cmd.ins    = fire;
          count_next      = count + CW'(1);
          rsp_next.status = spq_pkg::ST_ADDED;
        end
      end
      spq_pkg::MODE_EXEC: begin
        if (empty) begin
          rsp_next.status = spq_pkg::ST_EMPTY;
        end else begin
          cell_cmd.del          = fire;
          count_next            = count - CW'(1);
          rsp_next.status       = spq_pkg::ST_EXEC;
          rsp_next.out_name     = ent[0].name;
          rsp_next.out_priority = ent[0].prio;
        end
      end
      default: rsp_next.status = spq_pkg::ST_EMPTY;
    endcase
    rsp_next.occupancy = spq_pkg::OCC_W'(count_next);
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic             occ;
    logic             lk;
    spq_pkg::entry_t  le;
    spq_pkg::entry_t  re;

    assign occ = (IDX < count);

    if (i == 0) begin : g_head
      assign lk = 1'b1;
      assign le = ent[i];
    end else begin : g_body
      assign lk = keep[i-1];
      assign le = ent[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign re = ent[i];
    end else begin : g_mid
      assign re = ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cell_cmd),
      .occupied  (occ),
      .left_keep (lk),
      .left_ent  (le),
      .right_ent (re),
      .keep      (keep[i]),
      .ent       (ent[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (fire) begin
        count <= count_next;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== hw/rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_port_checker #(
  parameter int unsigned DEPTH = spq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input spq_pkg::req_t  cmd,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input spq_pkg::rsp_t  rsp
);

  // Every accepted request yields a result on the next cycle.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> rsp_valid)
    else $error("no result after accepted request");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  a_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == spq_pkg::ST_EMPTY |->
      rsp.occupancy == '0 && rsp.out_name == '0 && rsp.out_priority == '0)
    else $error("empty result carries data");

  a_full_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == spq_pkg::ST_FULL |->
      rsp.occupancy == spq_pkg::OCC_W'(DEPTH) && rsp.out_name == '0)
    else $error("dropped add with wrong occupancy");

endmodule

bind sorted_priority_queue_core spq_port_checker #(.DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);
